@@ rtl/i2cms_pkg.sv @@
package i2cms_pkg;

  localparam int unsigned TxDepth = 16;
  localparam int unsigned TxAw    = (TxDepth > 1) ? $clog2(TxDepth) : 1;

  localparam logic [2:0] ReqLoad    = 3'd0;
  localparam logic [2:0] ReqStartW  = 3'd1;
  localparam logic [2:0] ReqStartR  = 3'd2;
  localparam logic [2:0] ReqStartWr = 3'd3;
  localparam logic [2:0] ReqEvent   = 3'd4;
  localparam logic [2:0] ReqTick    = 3'd5;
  localparam logic [2:0] ReqAbort   = 3'd6;

  localparam logic [3:0] PhIdle     = 4'd0;
  localparam logic [3:0] PhAddrW    = 4'd2;
  localparam logic [3:0] PhAddrR    = 4'd3;
  localparam logic [3:0] PhWrite    = 4'd4;
  localparam logic [3:0] PhRead     = 4'd6;
  localparam logic [3:0] PhComplete = 4'd8;
  localparam logic [3:0] PhError    = 4'd9;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StTimeout = 3'd3;
  localparam logic [2:0] StBus     = 3'd4;
  localparam logic [2:0] StArb     = 3'd5;
  localparam logic [2:0] StNack    = 3'd6;

  localparam logic [2:0] CmdNone     = 3'd0;
  localparam logic [2:0] CmdStop     = 3'd1;
  localparam logic [2:0] CmdRepStart = 3'd2;
  localparam logic [2:0] CmdRecvAck  = 3'd3;
  localparam logic [2:0] CmdRecvNack = 3'd4;

  localparam logic [1:0] ReplyOk   = 2'd0;
  localparam logic [1:0] ReplyBad  = 2'd1;
  localparam logic [1:0] ReplyBusy = 2'd2;

  localparam logic ReadAddrBit = 1'b1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [6:0]  dev_addr;
    logic [4:0]  tx_len;
    logic [7:0]  rx_len;
    logic [15:0] timeout_ticks;
    logic [3:0]  tx_slot;
    logic [7:0]  byte_value;
    logic        bus_error;
    logic        arb_lost;
    logic        write_done;
    logic        read_done;
    logic        nack_seen;
  } in_item_t;

  // Result fields known at accept time; the data byte comes from the buffer's registered read port.
  typedef struct packed {
    logic [2:0] bus_command;
    logic       addr_valid;
    logic [7:0] addr_byte;
    logic       data_valid;
    logic       rx_write;
    logic [7:0] rx_index;
    logic [7:0] rx_value;
    logic [3:0] state_code;
    logic [2:0] status_code;
    logic       busy_res;
    logic [1:0] reply_code;
  } res_t;

  typedef struct packed {
    logic            we;
    logic [TxAw-1:0] waddr;
    logic [7:0]      wdata;
    logic            re;
    logic [TxAw-1:0] raddr;
  } ram_req_t;

endpackage

@@ rtl/i2cms_if.sv @@
interface i2cms_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [6:0]  dev_addr;
  logic [4:0]  tx_len;
  logic [7:0]  rx_len;
  logic [15:0] timeout_ticks;
  logic [3:0]  tx_slot;
  logic [7:0]  byte_value;
  logic        bus_error;
  logic        arb_lost;
  logic        write_done;
  logic        read_done;
  logic        nack_seen;

  modport source (
    output valid, req_type, dev_addr, tx_len, rx_len, timeout_ticks, tx_slot,
           byte_value, bus_error, arb_lost, write_done, read_done, nack_seen,
    input  ready
  );
  modport sink (
    input  valid, req_type, dev_addr, tx_len, rx_len, timeout_ticks, tx_slot,
           byte_value, bus_error, arb_lost, write_done, read_done, nack_seen,
    output ready
  );
endinterface

interface i2cms_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_command;
  logic       addr_valid;
  logic [7:0] addr_byte;
  logic       data_valid;
  logic [7:0] data_byte;
  logic       rx_write;
  logic [7:0] rx_index;
  logic [7:0] rx_value;
  logic [3:0] state_code;
  logic [2:0] status_code;
  logic       busy_res;
  logic [1:0] reply_code;

  modport source (
    output valid, bus_command, addr_valid, addr_byte, data_valid, data_byte, rx_write,
           rx_index, rx_value, state_code, status_code, busy_res, reply_code,
    input  ready
  );
  modport sink (
    input  valid, bus_command, addr_valid, addr_byte, data_valid, data_byte, rx_write,
           rx_index, rx_value, state_code, status_code, busy_res, reply_code,
    output ready
  );
endinterface

@@ rtl/i2cms_ram.sv @@
module i2cms_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                   wdata_i,
  input  logic                               re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                   rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/i2cms_ctrl.sv @@
module i2cms_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  i2cms_pkg::in_item_t item_i,
  output i2cms_pkg::res_t     res_o,
  output i2cms_pkg::ram_req_t ram_o
);

  logic [3:0]  phase_q, phase_d;
  logic [2:0]  status_q, status_d;
  logic        active_q, active_d;
  logic [6:0]  addr_q, addr_d;
  logic [4:0]  wcount_q, wcount_d;
  logic [4:0]  wpos_q, wpos_d;
  logic [7:0]  rcount_q, rcount_d;
  logic [7:0]  rpos_q, rpos_d;
  logic        rfollow_q, rfollow_d;
  logic [15:0] tlimit_q, tlimit_d;
  logic [15:0] elapsed_q, elapsed_d;

  logic        need_w, need_r, bad_param;
  logic [15:0] elapsed_inc;
  logic [7:0]  rpos_inc;
  logic        slot_ok;

  always_comb begin
    phase_d   = phase_q;
    status_d  = status_q;
    active_d  = active_q;
    addr_d    = addr_q;
    wcount_d  = wcount_q;
    wpos_d    = wpos_q;
    rcount_d  = rcount_q;
    rpos_d    = rpos_q;
    rfollow_d = rfollow_q;
    tlimit_d  = tlimit_q;
    elapsed_d = elapsed_q;
    res_o     = '0;
    ram_o     = '0;

    need_w    = (item_i.req_type != i2cms_pkg::ReqStartR);
    need_r    = (item_i.req_type != i2cms_pkg::ReqStartW);
    bad_param = (need_w && (item_i.tx_len == '0 ||
                            32'(item_i.tx_len) > i2cms_pkg::TxDepth)) ||
                (need_r && item_i.rx_len == '0);
    elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
    rpos_inc    = (rpos_q != 8'hFF) ? rpos_q + 8'd1 : rpos_q;
    slot_ok     = (32'(item_i.tx_slot) < i2cms_pkg::TxDepth);

    case (item_i.req_type)
      i2cms_pkg::ReqLoad: begin
        if (slot_ok) begin
          ram_o.we    = accept_i;
          ram_o.waddr = i2cms_pkg::TxAw'(item_i.tx_slot);
          ram_o.wdata = item_i.byte_value;
        end
      end
      i2cms_pkg::ReqStartW, i2cms_pkg::ReqStartR, i2cms_pkg::ReqStartWr: begin
        if (bad_param) begin
          res_o.reply_code = i2cms_pkg::ReplyBad;
        end else if (active_q) begin
          res_o.reply_code = i2cms_pkg::ReplyBusy;
        end else begin
          active_d  = 1'b1;
          addr_d    = item_i.dev_addr;
          wcount_d  = need_w ? item_i.tx_len : '0;
          wpos_d    = '0;
          rcount_d  = need_r ? item_i.rx_len : '0;
          rpos_d    = '0;
          rfollow_d = (item_i.req_type == i2cms_pkg::ReqStartWr);
          tlimit_d  = item_i.timeout_ticks;
          elapsed_d = '0;
          status_d  = i2cms_pkg::StOk;
          res_o.addr_valid = 1'b1;
          if (need_w) begin
            res_o.addr_byte = {item_i.dev_addr, 1'b0};
            phase_d = i2cms_pkg::PhAddrW;
          end else begin
            res_o.addr_byte = {item_i.dev_addr, i2cms_pkg::ReadAddrBit};
            phase_d = i2cms_pkg::PhAddrR;
          end
        end
      end
      i2cms_pkg::ReqEvent: begin
        if (active_q) begin
          if (item_i.bus_error) begin
            res_o.bus_command = i2cms_pkg::CmdStop;
            status_d = i2cms_pkg::StBus;
            phase_d  = i2cms_pkg::PhError;
            active_d = 1'b0;
          end else if (item_i.arb_lost) begin
            res_o.bus_command = i2cms_pkg::CmdStop;
            status_d = i2cms_pkg::StArb;
            phase_d  = i2cms_pkg::PhError;
            active_d = 1'b0;
          end else if (item_i.write_done) begin
            if (item_i.nack_seen) begin
              res_o.bus_command = i2cms_pkg::CmdStop;
              status_d = i2cms_pkg::StNack;
              phase_d  = i2cms_pkg::PhError;
              active_d = 1'b0;
            end else if (wpos_q < wcount_q) begin
              // The byte itself is read from the buffer and joins the result when stage 1 moves to the output register.
              res_o.data_valid = 1'b1;
              ram_o.re    = accept_i;
              ram_o.raddr = i2cms_pkg::TxAw'(wpos_q);
              wpos_d  = wpos_q + 5'd1;
              phase_d = i2cms_pkg::PhWrite;
            end else if (rfollow_q && rcount_q != '0) begin
              res_o.bus_command = i2cms_pkg::CmdRepStart;
              res_o.addr_valid  = 1'b1;
              res_o.addr_byte   = {addr_q, i2cms_pkg::ReadAddrBit};
              phase_d = i2cms_pkg::PhAddrR;
            end else begin
              res_o.bus_command = i2cms_pkg::CmdStop;
              status_d = i2cms_pkg::StOk;
              phase_d  = i2cms_pkg::PhComplete;
              active_d = 1'b0;
            end
          end else if (item_i.read_done) begin
            if (rpos_q < rcount_q) begin
              res_o.rx_write = 1'b1;
              res_o.rx_index = rpos_q;
              res_o.rx_value = item_i.byte_value;
            end
            rpos_d  = rpos_inc;
            phase_d = i2cms_pkg::PhRead;
            if (rpos_inc < rcount_q) begin
              res_o.bus_command = (rpos_inc == rcount_q - 8'd1) ?
                                  i2cms_pkg::CmdRecvNack : i2cms_pkg::CmdRecvAck;
            end else begin
              res_o.bus_command = i2cms_pkg::CmdStop;
              status_d = i2cms_pkg::StOk;
              phase_d  = i2cms_pkg::PhComplete;
              active_d = 1'b0;
            end
          end
        end
      end
      i2cms_pkg::ReqTick: begin
        if (active_q) begin
          elapsed_d = elapsed_inc;
          if (tlimit_q != '0 && elapsed_inc >= tlimit_q) begin
            res_o.bus_command = i2cms_pkg::CmdStop;
            status_d = i2cms_pkg::StTimeout;
            phase_d  = i2cms_pkg::PhError;
            active_d = 1'b0;
          end
        end
      end
      i2cms_pkg::ReqAbort: begin
        phase_d   = i2cms_pkg::PhIdle;
        status_d  = i2cms_pkg::StOk;
        active_d  = 1'b0;
        addr_d    = '0;
        wcount_d  = '0;
        wpos_d    = '0;
        rcount_d  = '0;
        rpos_d    = '0;
        rfollow_d = 1'b0;
        tlimit_d  = '0;
        elapsed_d = '0;
        res_o.bus_command = i2cms_pkg::CmdStop;
      end
      default: begin
      end
    endcase

    res_o.state_code  = phase_d;
    res_o.status_code = status_d;
    res_o.busy_res    = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= i2cms_pkg::PhIdle;
      status_q  <= i2cms_pkg::StOk;
      active_q  <= 1'b0;
      addr_q    <= '0;
      wcount_q  <= '0;
      wpos_q    <= '0;
      rcount_q  <= '0;
      rpos_q    <= '0;
      rfollow_q <= 1'b0;
      tlimit_q  <= '0;
      elapsed_q <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      status_q  <= status_d;
      active_q  <= active_d;
      addr_q    <= addr_d;
      wcount_q  <= wcount_d;
      wpos_q    <= wpos_d;
      rcount_q  <= rcount_d;
      rpos_q    <= rpos_d;
      rfollow_q <= rfollow_d;
      tlimit_q  <= tlimit_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

@@ rtl/i2c_master_transaction_sequencer.sv @@
// Path: an accepted input item passes through the stage 1 register and then the output register.
// Throughput: one item per cycle while the sink takes results, set by the single transmit buffer port used per item.
// Reset: rst_ni clears the transaction state and both pipeline valid flags at once.
// The transmit buffer is not cleared; a slot reads as undefined until a load writes it.
module i2c_master_transaction_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cms_req_if.sink   req_i,
  i2cms_rsp_if.source rsp_o
);

  // Stage 0 is the accept cycle: the controller decides the whole transaction step from
  // its registered state and, for a transmit acknowledge, starts a buffer read at the
  // current write position. Stage 1 holds the decided result while the buffer read
  // completes. The output register then merges in the buffer byte and holds the item
  // until the sink takes it; while a result waits, stage 1 can still take one more item.

  i2cms_pkg::in_item_t item;
  i2cms_pkg::res_t     res;
  i2cms_pkg::ram_req_t ram_req;

  logic            in_accept;
  logic            s1_valid_q;
  i2cms_pkg::res_t s1_res_q;
  logic            s1_move;
  logic            out_valid_q;
  i2cms_pkg::res_t out_res_q;
  logic [7:0]      out_data_q;
  logic [7:0]      ram_rdata;

  assign item.req_type      = req_i.req_type;
  assign item.dev_addr      = req_i.dev_addr;
  assign item.tx_len        = req_i.tx_len;
  assign item.rx_len        = req_i.rx_len;
  assign item.timeout_ticks = req_i.timeout_ticks;
  assign item.tx_slot       = req_i.tx_slot;
  assign item.byte_value    = req_i.byte_value;
  assign item.bus_error     = req_i.bus_error;
  assign item.arb_lost      = req_i.arb_lost;
  assign item.write_done    = req_i.write_done;
  assign item.read_done     = req_i.read_done;
  assign item.nack_seen     = req_i.nack_seen;

  // Stage 1 empties into the output register whenever that register is free or drained.
  assign s1_move     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_move;
  assign in_accept   = req_i.valid && req_i.ready;

  i2cms_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (item),
    .res_o    (res),
    .ram_o    (ram_req)
  );

  // The read data register only changes on an accepted item, so it stays aligned with
  // stage 1 while that stage is stalled. A load and a later read of the same slot are
  // always in different cycles, so the read sees the new byte without forwarding.
  i2cms_ram #(
    .Width (8),
    .Depth (i2cms_pkg::TxDepth)
  ) u_tx_buf (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_res_q <= res;
    end
    if (s1_move) begin
      out_res_q  <= s1_res_q;
      out_data_q <= s1_res_q.data_valid ? ram_rdata : 8'd0;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.bus_command = out_res_q.bus_command;
  assign rsp_o.addr_valid  = out_res_q.addr_valid;
  assign rsp_o.addr_byte   = out_res_q.addr_byte;
  assign rsp_o.data_valid  = out_res_q.data_valid;
  assign rsp_o.data_byte   = out_data_q;
  assign rsp_o.rx_write    = out_res_q.rx_write;
  assign rsp_o.rx_index    = out_res_q.rx_index;
  assign rsp_o.rx_value    = out_res_q.rx_value;
  assign rsp_o.state_code  = out_res_q.state_code;
  assign rsp_o.status_code = out_res_q.status_code;
  assign rsp_o.busy_res    = out_res_q.busy_res;
  assign rsp_o.reply_code  = out_res_q.reply_code;

endmodule

@@ rtl/i2cms_checker.sv @@
module i2cms_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_i,
  input logic [2:0] bus_command_i,
  input logic       addr_valid_i,
  input logic [7:0] addr_byte_i,
  input logic [3:0] state_code_i,
  input logic       busy_res_i,
  input logic [1:0] reply_code_i
);

  // A result item waiting for the sink does not vanish.
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("result item dropped while stalled");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !addr_valid_i |-> addr_byte_i == 8'd0)
    else $error("address byte set without address request");

  // A running transaction is always in one of the four bus phases.
  a_busy_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && busy_res_i |->
      state_code_i == i2cms_pkg::PhAddrW || state_code_i == i2cms_pkg::PhAddrR ||
      state_code_i == i2cms_pkg::PhWrite || state_code_i == i2cms_pkg::PhRead)
    else $error("busy outside a bus phase");

  // A rejected start request leaves the bus alone.
  a_reject_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && reply_code_i != i2cms_pkg::ReplyOk |->
      bus_command_i == i2cms_pkg::CmdNone && !addr_valid_i)
    else $error("rejected start drove the bus");

endmodule

bind i2c_master_transaction_sequencer i2cms_checker u_i2cms_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (rsp_o.valid),
  .ready_i       (rsp_o.ready),
  .bus_command_i (rsp_o.bus_command),
  .addr_valid_i  (rsp_o.addr_valid),
  .addr_byte_i   (rsp_o.addr_byte),
  .state_code_i  (rsp_o.state_code),
  .busy_res_i    (rsp_o.busy_res),
  .reply_code_i  (rsp_o.reply_code)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  // Request type 7 is not decoded by the sequencer and must leave it untouched.
  localparam logic [2:0] ReqUnused = 3'd7;

  // Upper bound on the cycles spent waiting for the pipeline to drain.
  localparam int unsigned DrainLimit = 20000;

  // One result item as it appears on the response channel.
  typedef struct packed {
    logic [2:0] bus_command;
    logic       addr_valid;
    logic [7:0] addr_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       rx_write;
    logic [7:0] rx_index;
    logic [7:0] rx_value;
    logic [3:0] state_code;
    logic [2:0] status_code;
    logic       busy_res;
    logic [1:0] reply_code;
  } seq_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #6 clk_i = ~clk_i;

  i2cms_req_if req_if ();
  i2cms_rsp_if rsp_if ();

  i2c_master_transaction_sequencer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Items waiting to be driven, and the results the sequencer still owes us.
  i2cms_pkg::in_item_t pending_requests[$];
  seq_result_t         expected_results[$];

  // Slots of the transmit buffer that a load has already written. A write
  // start is only ever queued after every slot it may send from is loaded.
  bit [i2cms_pkg::TxDepth-1:0] slot_loaded;

  int unsigned stim_count;
  int unsigned mismatch_count;
  bit          no_idle;

  // Shadow copy of the sequencer's transaction state.
  logic [3:0]  xfer_phase;
  logic [2:0]  xfer_status;
  logic        xfer_active;
  logic [6:0]  xfer_addr;
  logic [4:0]  wr_count;
  logic [4:0]  wr_pos;
  logic [7:0]  rd_count;
  logic [7:0]  rd_pos;
  logic        rd_follows;
  logic [15:0] tick_limit;
  logic [15:0] tick_elapsed;
  logic [7:0]  tx_image[i2cms_pkg::TxDepth];

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_xfer_state();
    xfer_phase   = i2cms_pkg::PhIdle;
    xfer_status  = i2cms_pkg::StOk;
    xfer_active  = 1'b0;
    xfer_addr    = '0;
    wr_count     = '0;
    wr_pos       = '0;
    rd_count     = '0;
    rd_pos       = '0;
    rd_follows   = 1'b0;
    tick_limit   = '0;
    tick_elapsed = '0;
  endfunction

  // Ends the running transaction; the caller issues the STOP.
  function automatic void close_xfer(logic [3:0] end_phase, logic [2:0] end_status);
    xfer_phase  = end_phase;
    xfer_status = end_status;
    xfer_active = 1'b0;
  endfunction

  // Works out the result item for one accepted request and advances the
  // shadow state, in the order the sequencer applies it.
  function automatic seq_result_t predict_bus_result(i2cms_pkg::in_item_t it);
    seq_result_t r;
    logic        need_w;
    logic        need_r;
    r = '0;
    case (it.req_type)
      i2cms_pkg::ReqLoad: begin
        tx_image[it.tx_slot] = it.byte_value;
      end
      i2cms_pkg::ReqStartW, i2cms_pkg::ReqStartR, i2cms_pkg::ReqStartWr: begin
        need_w = (it.req_type != i2cms_pkg::ReqStartR);
        need_r = (it.req_type != i2cms_pkg::ReqStartW);
        // The parameter check wins over the busy check.
        if ((need_w && (it.tx_len == 0 || it.tx_len > i2cms_pkg::TxDepth)) ||
            (need_r && it.rx_len == 0)) begin
          r.reply_code = i2cms_pkg::ReplyBad;
        end else if (xfer_active) begin
          r.reply_code = i2cms_pkg::ReplyBusy;
        end else begin
          xfer_active  = 1'b1;
          xfer_addr    = it.dev_addr;
          wr_count     = need_w ? it.tx_len : 5'd0;
          wr_pos       = '0;
          rd_count     = need_r ? it.rx_len : 8'd0;
          rd_pos       = '0;
          rd_follows   = (it.req_type == i2cms_pkg::ReqStartWr);
          tick_limit   = it.timeout_ticks;
          tick_elapsed = '0;
          xfer_status  = i2cms_pkg::StOk;
          r.addr_valid = 1'b1;
          if (need_w) begin
            r.addr_byte = {xfer_addr, 1'b0};
            xfer_phase  = i2cms_pkg::PhAddrW;
          end else begin
            r.addr_byte = {xfer_addr, i2cms_pkg::ReadAddrBit};
            xfer_phase  = i2cms_pkg::PhAddrR;
          end
        end
      end
      i2cms_pkg::ReqEvent: begin
        // Flags are taken in priority order; an event outside a transaction
        // or with no flag set does nothing.
        if (xfer_active) begin
          if (it.bus_error) begin
            r.bus_command = i2cms_pkg::CmdStop;
            close_xfer(i2cms_pkg::PhError, i2cms_pkg::StBus);
          end else if (it.arb_lost) begin
            r.bus_command = i2cms_pkg::CmdStop;
            close_xfer(i2cms_pkg::PhError, i2cms_pkg::StArb);
          end else if (it.write_done) begin
            if (it.nack_seen) begin
              r.bus_command = i2cms_pkg::CmdStop;
              close_xfer(i2cms_pkg::PhError, i2cms_pkg::StNack);
            end else if (wr_pos < wr_count) begin
              r.data_valid = 1'b1;
              r.data_byte  = (wr_pos < i2cms_pkg::TxDepth) ?
                             tx_image[wr_pos[i2cms_pkg::TxAw-1:0]] : 8'd0;
              wr_pos       = wr_pos + 5'd1;
              xfer_phase   = i2cms_pkg::PhWrite;
            end else if (rd_follows && rd_count != 0) begin
              // All write bytes are out: turn the bus around for the read.
              r.bus_command = i2cms_pkg::CmdRepStart;
              r.addr_valid  = 1'b1;
              r.addr_byte   = {xfer_addr, i2cms_pkg::ReadAddrBit};
              xfer_phase    = i2cms_pkg::PhAddrR;
            end else begin
              r.bus_command = i2cms_pkg::CmdStop;
              close_xfer(i2cms_pkg::PhComplete, i2cms_pkg::StOk);
            end
          end else if (it.read_done) begin
            if (rd_pos < rd_count) begin
              r.rx_write = 1'b1;
              r.rx_index = rd_pos;
              r.rx_value = it.byte_value;
            end
            if (rd_pos != 8'hFF) begin
              rd_pos = rd_pos + 8'd1;
            end
            xfer_phase = i2cms_pkg::PhRead;
            // The last byte to come is received with NACK.
            if (rd_pos < rd_count) begin
              r.bus_command = (rd_pos == rd_count - 8'd1) ? i2cms_pkg::CmdRecvNack :
                                                           i2cms_pkg::CmdRecvAck;
            end else begin
              r.bus_command = i2cms_pkg::CmdStop;
              close_xfer(i2cms_pkg::PhComplete, i2cms_pkg::StOk);
            end
          end
        end
      end
      i2cms_pkg::ReqTick: begin
        if (xfer_active) begin
          if (tick_elapsed != 16'hFFFF) begin
            tick_elapsed = tick_elapsed + 16'd1;
          end
          if (tick_limit != 0 && tick_elapsed >= tick_limit) begin
            r.bus_command = i2cms_pkg::CmdStop;
            close_xfer(i2cms_pkg::PhError, i2cms_pkg::StTimeout);
          end
        end
      end
      i2cms_pkg::ReqAbort: begin
        clear_xfer_state();
        r.bus_command = i2cms_pkg::CmdStop;
      end
      default: begin
      end
    endcase
    r.state_code  = xfer_phase;
    r.status_code = xfer_status;
    r.busy_res    = xfer_active;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  function automatic bit coin();
    return $urandom_range(0, 1) == 1;
  endfunction

  // Every field random; callers overwrite the ones that matter.
  function automatic i2cms_pkg::in_item_t random_item();
    i2cms_pkg::in_item_t it;
    it.req_type      = 3'($urandom_range(0, 7));
    it.dev_addr      = 7'($urandom_range(0, 127));
    it.tx_len        = 5'($urandom_range(0, 31));
    it.rx_len        = 8'($urandom_range(0, 255));
    it.timeout_ticks = 16'($urandom_range(0, 65535));
    it.tx_slot       = 4'($urandom_range(0, 15));
    it.byte_value    = 8'($urandom_range(0, 255));
    it.bus_error     = coin();
    it.arb_lost      = coin();
    it.write_done    = coin();
    it.read_done     = coin();
    it.nack_seen     = coin();
    return it;
  endfunction

  // Queues one item. A valid write start is preceded by loads of any slot it
  // could send from that has not been written yet.
  task automatic push_req(i2cms_pkg::in_item_t it);
    i2cms_pkg::in_item_t fill;
    int unsigned         s;
    if ((it.req_type == i2cms_pkg::ReqStartW || it.req_type == i2cms_pkg::ReqStartWr) &&
        it.tx_len != 0 && it.tx_len <= i2cms_pkg::TxDepth) begin
      for (s = 0; s < it.tx_len; s++) begin
        if (!slot_loaded[s]) begin
          fill          = random_item();
          fill.req_type = i2cms_pkg::ReqLoad;
          fill.tx_slot  = 4'(s);
          slot_loaded[s] = 1'b1;
          pending_requests.push_back(fill);
          stim_count++;
        end
      end
    end
    if (it.req_type == i2cms_pkg::ReqLoad) begin
      slot_loaded[it.tx_slot] = 1'b1;
    end
    pending_requests.push_back(it);
    if (it.req_type != ReqUnused) begin
      stim_count++;
    end
  endtask

  task automatic push_simple(logic [2:0] kind);
    i2cms_pkg::in_item_t it;
    it          = random_item();
    it.req_type = kind;
    push_req(it);
  endtask

  task automatic push_load(logic [3:0] slot, logic [7:0] value);
    i2cms_pkg::in_item_t it;
    it            = random_item();
    it.req_type   = i2cms_pkg::ReqLoad;
    it.tx_slot    = slot;
    it.byte_value = value;
    push_req(it);
  endtask

  task automatic push_start(logic [2:0] kind, logic [6:0] addr, logic [4:0] wl,
                            logic [7:0] rl, logic [15:0] ticks);
    i2cms_pkg::in_item_t it;
    it               = random_item();
    it.req_type      = kind;
    it.dev_addr      = addr;
    it.tx_len        = wl;
    it.rx_len        = rl;
    it.timeout_ticks = ticks;
    push_req(it);
  endtask

  task automatic push_bus_event(bit bus, bit arb, bit wr, bit rd, bit nack,
                                logic [7:0] value);
    i2cms_pkg::in_item_t it;
    it            = random_item();
    it.req_type   = i2cms_pkg::ReqEvent;
    it.bus_error  = bus;
    it.arb_lost   = arb;
    it.write_done = wr;
    it.read_done  = rd;
    it.nack_seen  = nack;
    it.byte_value = value;
    push_req(it);
  endtask

  // One well-formed transaction: the start, the acknowledges of the address
  // and data bytes, then the received bytes. Ticks, loads and stray starts
  // are mixed in, and about one transaction in five is cut short by a fault.
  task automatic run_transfer();
    logic [2:0]          kind;
    logic [4:0]          wl;
    logic [7:0]          rl;
    logic [15:0]         ticks;
    int unsigned         pick;
    int unsigned         n_wr;
    int unsigned         n_rd;
    int unsigned         total;
    int unsigned         fault_at;
    int unsigned         i;
    i2cms_pkg::in_item_t stray;
    pick = $urandom_range(0, 2);
    kind = (pick == 0) ? i2cms_pkg::ReqStartW :
           (pick == 1) ? i2cms_pkg::ReqStartR : i2cms_pkg::ReqStartWr;
    wl = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(1, i2cms_pkg::TxDepth)) :
                                       5'($urandom_range(1, 4));
    // Long reads are rare so that they do not dominate the run.
    pick = $urandom_range(0, 49);
    rl = (pick == 0) ? 8'd255 :
         (pick < 3)  ? 8'($urandom_range(7, 64)) : 8'($urandom_range(1, 6));
    pick = $urandom_range(0, 19);
    ticks = (pick < 10) ? 16'd0 :
            (pick < 13) ? 16'($urandom_range(1, 5)) : 16'($urandom_range(6, 65535));
    n_wr = (kind != i2cms_pkg::ReqStartR) ? int'(wl) + 1 : 0;
    // Now and then the read address is acknowledged like a write byte.
    if (kind == i2cms_pkg::ReqStartWr && $urandom_range(0, 9) == 0) begin
      n_wr++;
    end
    n_rd  = (kind != i2cms_pkg::ReqStartW) ? int'(rl) : 0;
    total = n_wr + n_rd;
    fault_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, total - 1) : total;

    push_start(kind, 7'($urandom_range(0, 127)), wl, rl, ticks);
    for (i = 0; i < total; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_simple(i2cms_pkg::ReqTick);
      end
      if ($urandom_range(0, 29) == 0) begin
        push_load(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 39) == 0) begin
        stray          = random_item();
        stray.req_type = 3'($urandom_range(1, 3));
        push_req(stray);
      end
      if (i == fault_at) begin
        case ($urandom_range(0, 4))
          0: push_bus_event(1'b1, coin(), coin(), coin(), coin(), 8'($urandom_range(0, 255)));
          1: push_bus_event(1'b0, 1'b1, coin(), coin(), coin(), 8'($urandom_range(0, 255)));
          2: push_bus_event(1'b0, 1'b0, 1'b1, coin(), 1'b1, 8'($urandom_range(0, 255)));
          3: push_simple(i2cms_pkg::ReqAbort);
          default: repeat (6) push_simple(i2cms_pkg::ReqTick);
        endcase
        return;
      end
      if (i < n_wr) begin
        push_bus_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'($urandom_range(0, 255)));
      end else begin
        push_bus_event(1'b0, 1'b0, 1'b0, 1'b1, coin(), 8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      push_simple(i2cms_pkg::ReqTick);
    end
  endtask

  // Mostly well-formed transactions; the rest is a short burst of random
  // items, often followed by an abort to bring the sequencer back to idle.
  task automatic random_round();
    int unsigned n;
    if ($urandom_range(0, 6) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) push_req(random_item());
      if (coin()) begin
        push_simple(i2cms_pkg::ReqAbort);
      end
    end else begin
      run_transfer();
    end
  endtask

  // Returns once every queued item has been taken and every result seen.
  task automatic wait_for_drain();
    int unsigned guard;
    guard = 0;
    while ((pending_requests.size() != 0 || req_if.valid ||
            expected_results.size() != 0) && guard < DrainLimit) begin
      @(negedge clk_i);
      guard++;
    end
  endtask

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued items, with random gaps between them. The
  // expected result is worked out at the edge where the item is taken.
  // ---------------------------------------------------------------------------

  i2cms_pkg::in_item_t on_wire;
  int unsigned         send_gap;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_results.push_back(predict_bus_result(on_wire));
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap != 0 && !no_idle) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          on_wire = pending_requests.pop_front();
          req_if.req_type      <= on_wire.req_type;
          req_if.dev_addr      <= on_wire.dev_addr;
          req_if.tx_len        <= on_wire.tx_len;
          req_if.rx_len        <= on_wire.rx_len;
          req_if.timeout_ticks <= on_wire.timeout_ticks;
          req_if.tx_slot       <= on_wire.tx_slot;
          req_if.byte_value    <= on_wire.byte_value;
          req_if.bus_error     <= on_wire.bus_error;
          req_if.arb_lost      <= on_wire.arb_lost;
          req_if.write_done    <= on_wire.write_done;
          req_if.read_done     <= on_wire.read_done;
          req_if.nack_seen     <= on_wire.nack_seen;
          req_if.valid         <= 1'b1;
          if (!no_idle && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 3);
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes result items, stalling now and then, and compares each
  // one field by field with the oldest expectation.
  // ---------------------------------------------------------------------------

  seq_result_t want;
  int unsigned hold_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      hold_cycles = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result item arrived with nothing outstanding");
        end else begin
          want = expected_results.pop_front();
          if (rsp_if.bus_command !== want.bus_command)
            report_mismatch($sformatf("bus_command got %0d, expected %0d",
                                      rsp_if.bus_command, want.bus_command));
          if (rsp_if.addr_valid !== want.addr_valid)
            report_mismatch($sformatf("addr_valid got %0d, expected %0d",
                                      rsp_if.addr_valid, want.addr_valid));
          if (rsp_if.addr_byte !== want.addr_byte)
            report_mismatch($sformatf("addr_byte got %0h, expected %0h",
                                      rsp_if.addr_byte, want.addr_byte));
          if (rsp_if.data_valid !== want.data_valid)
            report_mismatch($sformatf("data_valid got %0d, expected %0d",
                                      rsp_if.data_valid, want.data_valid));
          if (rsp_if.data_byte !== want.data_byte)
            report_mismatch($sformatf("data_byte got %0h, expected %0h",
                                      rsp_if.data_byte, want.data_byte));
          if (rsp_if.rx_write !== want.rx_write)
            report_mismatch($sformatf("rx_write got %0d, expected %0d",
                                      rsp_if.rx_write, want.rx_write));
          if (rsp_if.rx_index !== want.rx_index)
            report_mismatch($sformatf("rx_index got %0d, expected %0d",
                                      rsp_if.rx_index, want.rx_index));
          if (rsp_if.rx_value !== want.rx_value)
            report_mismatch($sformatf("rx_value got %0h, expected %0h",
                                      rsp_if.rx_value, want.rx_value));
          if (rsp_if.state_code !== want.state_code)
            report_mismatch($sformatf("state_code got %0d, expected %0d",
                                      rsp_if.state_code, want.state_code));
          if (rsp_if.status_code !== want.status_code)
            report_mismatch($sformatf("status_code got %0d, expected %0d",
                                      rsp_if.status_code, want.status_code));
          if (rsp_if.busy_res !== want.busy_res)
            report_mismatch($sformatf("busy_res got %0d, expected %0d",
                                      rsp_if.busy_res, want.busy_res));
          if (rsp_if.reply_code !== want.reply_code)
            report_mismatch($sformatf("reply_code got %0d, expected %0d",
                                      rsp_if.reply_code, want.reply_code));
        end
      end
      if (hold_cycles != 0 && !no_idle) begin
        hold_cycles--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 7) == 0) begin
          hold_cycles = $urandom_range(1, 3);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned s;
    req_if.valid         = 1'b0;
    req_if.req_type      = i2cms_pkg::ReqLoad;
    req_if.dev_addr      = '0;
    req_if.tx_len        = '0;
    req_if.rx_len        = '0;
    req_if.timeout_ticks = '0;
    req_if.tx_slot       = '0;
    req_if.byte_value    = '0;
    req_if.bus_error     = 1'b0;
    req_if.arb_lost      = 1'b0;
    req_if.write_done    = 1'b0;
    req_if.read_done     = 1'b0;
    req_if.nack_seen     = 1'b0;
    rsp_if.ready         = 1'b0;
    rst_ni               = 1'b0;
    no_idle              = 1'b0;
    stim_count           = 0;
    mismatch_count       = 0;
    slot_loaded          = '0;
    for (s = 0; s < i2cms_pkg::TxDepth; s++) begin
      tx_image[s] = 8'd0;
    end
    clear_xfer_state();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Items the sequencer has to ignore come first: an
    // undecoded request type, and an event and a tick with no transaction.
    push_simple(ReqUnused);
    push_bus_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
    push_simple(i2cms_pkg::ReqTick);
    // Rejected parameters: zero write length, write length above the buffer
    // depth, zero read length.
    push_start(i2cms_pkg::ReqStartW, 7'd5, 5'd0, 8'd3, 16'd0);
    push_start(i2cms_pkg::ReqStartWr, 7'd5, 5'd17, 8'd3, 16'd0);
    push_start(i2cms_pkg::ReqStartR, 7'd5, 5'd4, 8'd0, 16'd0);
    // Largest write-read with the longest timeout. A busy start and a start
    // that is both busy and malformed must be answered without side effects;
    // an event with only the NACK flag is ignored and one with every flag is a bus error.
    push_load(4'd0, 8'h00);
    push_load(4'd15, 8'hFF);
    push_start(i2cms_pkg::ReqStartWr, 7'd127, 5'd16, 8'd255, 16'hFFFF);
    push_bus_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h5A);
    push_bus_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'hA5);
    push_start(i2cms_pkg::ReqStartR, 7'd3, 5'd0, 8'd9, 16'd0);
    push_start(i2cms_pkg::ReqStartW, 7'd3, 5'd0, 8'd9, 16'd0);
    push_bus_event(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h11);
    push_bus_event(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
    // Arbitration lost outranks a write acknowledge.
    push_start(i2cms_pkg::ReqStartW, 7'd0, 5'd1, 8'd0, 16'd0);
    push_bus_event(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00);
    // Timeout after two ticks.
    push_start(i2cms_pkg::ReqStartW, 7'd0, 5'd1, 8'd1, 16'd2);
    push_simple(i2cms_pkg::ReqTick);
    push_simple(i2cms_pkg::ReqTick);
    // Target NACKs the address byte.
    push_start(i2cms_pkg::ReqStartW, 7'd64, 5'd1, 8'd1, 16'd0);
    push_bus_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00);
    // Write-read of one byte out and two in; the read address is acknowledged as a
    // transmit byte twice, which repeats the START each time.
    push_start(i2cms_pkg::ReqStartWr, 7'd85, 5'd1, 8'd2, 16'd0);
    repeat (4) push_bus_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
    push_bus_event(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00);
    push_bus_event(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'hFF);
    // A byte received during a write-only transaction lies past the read
    // count: nothing is delivered and the transaction completes.
    push_start(i2cms_pkg::ReqStartW, 7'd42, 5'd1, 8'd1, 16'd0);
    push_bus_event(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h77);
    // Abort in the middle of a read.
    push_start(i2cms_pkg::ReqStartR, 7'd42, 5'd1, 8'd1, 16'd0);
    push_simple(i2cms_pkg::ReqAbort);

    // The sender holds off here until every result is back.
    wait_for_drain();

    while (stim_count < 700) begin
      random_round();
    end
    wait_for_drain();
    while (stim_count < 1400) begin
      random_round();
    end
    wait_for_drain();

    // Last part at full rate on both sides.
    no_idle = 1'b1;
    while (stim_count < 1600) begin
      random_round();
    end
    wait_for_drain();
    repeat (8) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #(5_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
